FILE: design/dad_pkg.sv
// dad_pkg: shared types, constants and calendar functions for the date adder
// depends on nothing; used by dad_ctrl, dad_datapath and date_add_days
package dad_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CLAMP,
		ST_WALK,
		ST_DONE
	} state_t;

	localparam logic [15:0] YEAR_MOD = 16'd400;
	localparam logic [8:0] YEAR_CYCLE_LAST = 9'd399;
	localparam logic [2:0] RED_TOP = 3'd7;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [4:0] LEN_LONG = 5'd31;
	localparam logic [4:0] LEN_SHORT = 5'd30;
	localparam logic [4:0] LEN_FEB = 5'd28;
	localparam logic [4:0] LEN_FEB_LEAP = 5'd29;

	typedef struct packed {
		logic load;
		logic reduce;
		logic clamp;
		logic walk;
		logic [2:0] shift;
	} ctrl_t;

	typedef struct packed {
		logic walk_end;
	} stat_t;

	// leap rule on the year taken modulo 400
	function automatic logic leap_of(input logic [8:0] ymod);
		logic century;
		century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
		return (ymod[1:0] == 2'b00) && !century;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = LEN_SHORT;
			MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage

FILE: design/dad_sub.sv
// dad_sub: the shared 16-bit subtract and compare unit
// used by dad_datapath for year reduction and for the month walk
module dad_sub (
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [15:0] diff,
	output logic        borrow
);
	logic [16:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[15:0];
	assign borrow = full[16];

endmodule

FILE: design/dad_ctrl.sv
// dad_ctrl: sequencer for the date adder
// depends on dad_pkg; drives dad_datapath through a ctrl_t word
module dad_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dad_pkg::stat_t stat,
	output dad_pkg::ctrl_t ctl,
	output logic           busy,
	output logic           done
);
	import dad_pkg::*;

	state_t state_q, state_nxt;
	logic [2:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			shift_q <= 3'd0;
		end else begin
			state_q <= state_nxt;
			if (ctl.load) begin
				shift_q <= RED_TOP;
			end else if (ctl.reduce) begin
				shift_q <= shift_q - 3'd1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (shift_q == 3'd0) begin
					state_nxt = ST_CLAMP;
				end
			end
			ST_CLAMP: state_nxt = ST_WALK;
			ST_WALK: begin
				if (stat.walk_end) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.load = (state_q == ST_IDLE) && start;
		ctl.reduce = (state_q == ST_REDUCE);
		ctl.clamp = (state_q == ST_CLAMP);
		ctl.walk = (state_q == ST_WALK);
		ctl.shift = shift_q;
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
	end

endmodule

FILE: design/dad_datapath.sv
// dad_datapath: date registers, year-mod-400 tracker and month length logic
// depends on dad_pkg and dad_sub
module dad_datapath (
	input  logic           clk,
	input  dad_pkg::ctrl_t ctl,
	input  logic [3:0]     month_in,
	input  logic [4:0]     day_in,
	input  logic [15:0]    year_in,
	input  logic [15:0]    days_to_add,
	output dad_pkg::stat_t stat,
	output logic [3:0]     month_out,
	output logic [4:0]     day_out,
	output logic [15:0]    year_out,
	output logic           year_overflow
);
	import dad_pkg::*;

	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [15:0] year_q;
	logic [15:0] left_q;
	logic [15:0] yrem_q;
	logic        ovf_q;

	logic        leap;
	logic [4:0]  len;
	logic [4:0]  rest;
	logic [15:0] sub_a, sub_b, diff;
	logic        borrow;

	assign leap = leap_of(yrem_q[8:0]);
	assign len = month_len(month_q, leap);
	assign rest = len - day_q;
	assign sub_a = ctl.reduce ? yrem_q : left_q;
	assign sub_b = ctl.reduce ? (YEAR_MOD << ctl.shift) : ({11'd0, rest} + 16'd1);

	dad_sub u_sub (
		.a(sub_a),
		.b(sub_b),
		.diff(diff),
		.borrow(borrow)
	);

	assign stat.walk_end = (left_q == 16'd0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (month_in == 4'd0) begin
				month_q <= MONTH_JAN;
			end else if (month_in > MONTH_DEC) begin
				month_q <= MONTH_DEC;
			end else begin
				month_q <= month_in;
			end
			day_q <= (day_in == 5'd0) ? 5'd1 : day_in;
			year_q <= year_in;
			yrem_q <= year_in;
			left_q <= days_to_add;
			ovf_q <= 1'b0;
		end else if (ctl.reduce) begin
			if (!borrow) begin
				yrem_q <= diff;
			end
		end else if (ctl.clamp) begin
			if (day_q > len) begin
				day_q <= len;
			end
		end else if (ctl.walk && !stat.walk_end) begin
			if (borrow) begin
				day_q <= day_q + left_q[4:0];
				left_q <= 16'd0;
			end else begin
				// finish this month and move to the first of the next
				left_q <= diff;
				day_q <= 5'd1;
				if (month_q == MONTH_DEC) begin
					month_q <= MONTH_JAN;
					if (year_q == 16'hFFFF) begin
						year_q <= 16'd0;
						yrem_q <= 16'd0;
						ovf_q <= 1'b1;
					end else begin
						year_q <= year_q + 16'd1;
						yrem_q <= (yrem_q[8:0] == YEAR_CYCLE_LAST) ? 16'd0 : yrem_q + 16'd1;
					end
				end else begin
					month_q <= month_q + 4'd1;
				end
			end
		end
	end

	assign month_out = month_q;
	assign day_out = day_q;
	assign year_out = year_q;
	assign year_overflow = ovf_q;

endmodule

FILE: design/date_add_days.sv
// date_add_days: top level of the Gregorian date adder
// depends on dad_pkg, dad_ctrl, dad_datapath (which holds dad_sub)
//
// channel  ports                                          handshake
// command  month_in, day_in, year_in, days_to_add         start high while busy low
// result   month_out, day_out, year_out, year_overflow    done high for one cycle
//
// busy is high from the accepting edge until the sequencer is back in idle, done in the last of those cycles
// the walk takes one step per month end crossed (up to about 2160), plus one when the word ends inside a month
// year reduction on the shared subtractor, then the clamp, then one walk step per cycle
// a new word is taken the cycle after done at the earliest
// arst_n clears the sequencer only; the result is taken in the done cycle, no stall
module date_add_days (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [15:0] year_in,
	input  logic [15:0] days_to_add,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [15:0] year_out,
	output logic        year_overflow
);
	import dad_pkg::*;

	ctrl_t ctl;
	stat_t stat;

	dad_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.ctl(ctl),
		.busy(busy),
		.done(done)
	);

	dad_datapath u_dp (
		.clk(clk),
		.ctl(ctl),
		.month_in(month_in),
		.day_in(day_in),
		.year_in(year_in),
		.days_to_add(days_to_add),
		.stat(stat),
		.month_out(month_out),
		.day_out(day_out),
		.year_out(year_out),
		.year_overflow(year_overflow)
	);

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for date_add_days, the Gregorian date adder
// needs dad_pkg and the date_add_days rtl; each word's result comes from a month-walking
// calendar model kept in this file, then checked against the done strobe in order
module tb;
	import dad_pkg::*;

	localparam int MONTH_APR = 4;
	localparam int MONTH_JUN = 6;
	localparam int MONTH_SEP = 9;
	localparam int MONTH_NOV = 11;
	localparam int YEAR_TOP = 65535;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2200;
	localparam int RANDOM_WORDS = 245;

	typedef struct {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] year;
		logic [15:0] span;
	} date_cmd_t;

	typedef struct {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] year;
		logic        wrapped;
	} date_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	logic [3:0]  month_in = '0;
	logic [4:0]  day_in = '0;
	logic [15:0] year_in = '0;
	logic [15:0] days_to_add = '0;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [15:0] year_out;
	logic        year_overflow;

	date_cmd_t cmd_q[$];
	date_res_t expected_dates[$];
	date_res_t next_date;
	int        error_count = 0;
	int        sent_count = 0;
	int        stall_cycles = 0;
	bit        gap_now;

	date_add_days u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.month_in      (month_in),
		.day_in        (day_in),
		.year_in       (year_in),
		.days_to_add   (days_to_add),
		.month_out     (month_out),
		.day_out       (day_out),
		.year_out      (year_out),
		.year_overflow (year_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit cal_leap(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int cal_month_len(input int m, input int y);
		if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
			return LEN_SHORT;
		if (m == MONTH_FEB)
			return cal_leap(y) ? LEN_FEB_LEAP : LEN_FEB;
		return LEN_LONG;
	endfunction

	// walk month by month from the clamped start date
	function automatic date_res_t advance_date(input date_cmd_t c);
		int        m;
		int        d;
		int        y;
		int        left;
		int        len;
		date_res_t r;
		m = c.month;
		d = c.day;
		y = c.year;
		left = c.span;
		r.wrapped = 1'b0;
		if (m == 0)
			m = MONTH_JAN;
		else if (m > MONTH_DEC)
			m = MONTH_DEC;
		if (d == 0)
			d = 1;
		len = cal_month_len(m, y);
		if (d > len)
			d = len;
		while (left > 0) begin
			len = cal_month_len(m, y);
			if (left <= len - d) begin
				d = d + left;
				left = 0;
			end else begin
				left = left - (len - d + 1);
				d = 1;
				if (m == MONTH_DEC) begin
					m = MONTH_JAN;
					if (y == YEAR_TOP) begin
						y = 0;
						r.wrapped = 1'b1;
					end else begin
						y = y + 1;
					end
				end else begin
					m = m + 1;
				end
			end
		end
		r.month = 4'(m);
		r.day = 5'(d);
		r.year = 16'(y);
		return r;
	endfunction

	task automatic queue_date(input int m, input int d, input int y, input int n);
		date_cmd_t c;
		c.month = 4'(m);
		c.day = 5'(d);
		c.year = 16'(y);
		c.span = 16'(n);
		cmd_q.push_back(c);
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_dates.push_back(advance_date(cmd_q.pop_front()));
				sent_count++;
			end
			if (!(start && busy)) begin
				gap_now = !(sent_count >= 120 && sent_count < 180) &&
					($urandom_range(99, 0) < 33);
				if (cmd_q.size() != 0 && !gap_now) begin
					start <= 1'b1;
					month_in <= cmd_q[0].month;
					day_in <= cmd_q[0].day;
					year_in <= cmd_q[0].year;
					days_to_add <= cmd_q[0].span;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_dates.size() == 0) begin
				report_mismatch($sformatf("unexpected word %0d/%0d/%0d ovf %0b",
					month_out, day_out, year_out, year_overflow));
			end else begin
				next_date = expected_dates.pop_front();
				if (month_out !== next_date.month || day_out !== next_date.day ||
					year_out !== next_date.year || year_overflow !== next_date.wrapped) begin
					report_mismatch($sformatf("got %0d/%0d/%0d ovf %0b, want %0d/%0d/%0d ovf %0b",
						month_out, day_out, year_out, year_overflow, next_date.month,
						next_date.day, next_date.year, next_date.wrapped));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int m;
		int d;
		int y;
		int n;
		int pick;

		// corners of each field and calendar rule
		queue_date(1, 1, 2024, 0);
		queue_date(0, 0, 2023, 0);
		queue_date(13, 5, 2023, 10);
		queue_date(15, 31, 65535, 1);
		queue_date(2, 31, 2023, 0);
		queue_date(2, 30, 2024, 0);
		queue_date(2, 29, 1900, 1);
		queue_date(2, 28, 2000, 1);
		queue_date(2, 28, 2100, 1);
		queue_date(4, 31, 2023, 0);
		queue_date(12, 31, 1999, 1);
		queue_date(1, 31, 2024, 29);
		queue_date(1, 1, 0, 65535);
		queue_date(12, 31, 65535, 65535);
		queue_date(12, 1, 65535, 30);
		queue_date(3, 15, 65500, 65535);
		queue_date(2, 1, 2000, 29);
		queue_date(2, 1, 1900, 28);
		queue_date(6, 30, 2023, 1);
		queue_date(11, 30, 2023, 31);
		queue_date(1, 1, 1600, 366);
		queue_date(12, 31, 0, 1);
		queue_date(7, 16, 21845, 43690);
		queue_date(10, 10, 43690, 21845);
		queue_date(5, 0, 400, 1);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if ($urandom_range(9, 0) != 0) begin
				m = $urandom_range(12, 1);
			end else begin
				pick = $urandom_range(3, 0);
				m = (pick == 0) ? 0 : 12 + pick;
			end
			pick = $urandom_range(9, 0);
			if (pick < 6)
				y = $urandom_range(2600, 1500);
			else if (pick < 8)
				y = $urandom_range(65535, 0);
			else
				y = $urandom_range(65535, 65000);
			if ($urandom_range(99, 0) < 85)
				d = $urandom_range(cal_month_len((m == 0) ? 1 : (m > 12 ? 12 : m), y), 1);
			else
				d = $urandom_range(31, 0);
			pick = $urandom_range(99, 0);
			if (pick < 40) begin
				n = $urandom_range(400, 0);
			end else if (pick < 75) begin
				n = $urandom_range(65535, 0);
			end else if (pick < 90) begin
				n = $urandom_range(3000, 0);
			end else begin
				pick = $urandom_range(4, 0);
				n = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 365 :
					(pick == 3) ? 366 : 65535;
			end
			queue_date(m, d, y, n);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while ((cmd_q.size() != 0 || start || expected_dates.size() != 0) &&
			stall_cycles < STALL_LIMIT)
			@(posedge clk);

		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (error_count == 0)
				$display("Testbench completed without errors");
			else
				$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
